// ----- hw/rtl/fire_heat_simulation_core_assert.svh -----
// Assertion macros shared by the fire heat simulation checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef FIRE_HEAT_SIMULATION_CORE_ASSERT_SVH
`define FIRE_HEAT_SIMULATION_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define FHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fire heat core: assertion failed");

// Next-cycle implication, disabled while reset is low
`define FHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fire heat core: assertion failed");

`endif

// ----- hw/rtl/fhs_pkg.sv -----
// Package for the fire heat simulation core: sizes, constants, codes and types.
// No dependencies; used by the top level, the remainder unit and the testbench.
`timescale 1ns / 1ps

package fhs_pkg;

    // Ring storage
    localparam int RING_MAX = 256;
    localparam int HEAT_AW  = $clog2(RING_MAX);
    localparam int LEN_W    = 9;

    // Remainder unit: 32-bit dividend, divisor up to RING_MAX
    localparam int DIVD_W    = 32;
    localparam int DIVS_W    = 9;
    localparam int MOD_STEP  = 8;
    localparam int MOD_CHUNK = DIVD_W / MOD_STEP;
    localparam int MOD_CW    = $clog2(MOD_CHUNK);

    // Frame arithmetic
    localparam logic [5:0]  COOL_BASE    = 6'd55;
    localparam logic [13:0] COOL_SCALE   = 14'd40;
    localparam logic [8:0]  SPARK_BASE   = 9'd160;
    localparam logic [8:0]  SPARK_SPAN   = 9'd96;
    localparam logic [19:0] BLUR_RECIP   = 20'd683;
    localparam int          BLUR_SHIFT   = 11;
    localparam logic [7:0]  PAL_LOW      = 8'd85;
    localparam logic [7:0]  PAL_HIGH     = 8'd170;
    localparam logic [7:0]  HEAT_FULL    = 8'd255;

    // Register reset values
    localparam logic [7:0]  COOL_RESET  = 8'd128;
    localparam logic [7:0]  SPARK_RESET = 8'd128;
    localparam logic [8:0]  LEN_RESET   = 9'd200;
    localparam logic [31:0] SEED_RESET  = 32'd2463534242;

    // Item actions
    localparam logic ACT_ADVANCE = 1'b0;
    localparam logic ACT_READ    = 1'b1;

    // Register map, one word each
    typedef enum logic [1:0] {
        CFG_COOLING = 2'd0,
        CFG_SPARK   = 2'd1,
        CFG_LENGTH  = 2'd2,
        CFG_SEED    = 2'd3
    } t_cfg_reg;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_PAL,
        ST_CL_DRAW,
        ST_CL_DIV,
        ST_BL_INIT0,
        ST_BL_INIT1,
        ST_BL_INIT2,
        ST_BL_RD,
        ST_BL_SUM,
        ST_BL_WR,
        ST_SP_DRAWP,
        ST_SP_DIVP,
        ST_SP_DRAWA,
        ST_SP_DIVA,
        ST_RESP
    } t_state;

    // Remainder unit request and response
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [DIVS_W-1:0] rem;
    } t_mod_rsp;

endpackage

// ----- hw/rtl/fhs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the heat cells of the fire heat simulation core.
`timescale 1ns / 1ps

module fhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/fhs_mod_unit.sv -----
// Shared remainder unit: 32-bit dividend mod 9-bit divisor, eight bits per cycle.
// Depends on fhs_pkg; result valid in the cycle done is high.
`timescale 1ns / 1ps

module fhs_mod_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fhs_pkg::t_mod_req i_req,
    output fhs_pkg::t_mod_rsp o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    logic [fhs_pkg::MOD_CW-1:0]   r_cnt;
    logic [fhs_pkg::DIVD_W-1:0]   r_num;
    logic [fhs_pkg::DIVS_W-1:0]   r_div;
    logic [fhs_pkg::DIVS_W-1:0]   r_rem;
    logic [fhs_pkg::DIVD_W-1:0]   n_num;
    logic [fhs_pkg::DIVS_W-1:0]   n_rem;

    // One chunk of restoring remainder steps, MSB first
    always_comb begin
        logic [fhs_pkg::DIVS_W:0]   t;
        logic [fhs_pkg::DIVD_W-1:0] num_v;
        logic [fhs_pkg::DIVS_W-1:0] rem_v;
        num_v = r_num;
        rem_v = r_rem;
        for (int k = 0; k < fhs_pkg::MOD_STEP; k++) begin
            t = {rem_v, num_v[fhs_pkg::DIVD_W-1]};
            num_v = {num_v[fhs_pkg::DIVD_W-2:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            rem_v = t[fhs_pkg::DIVS_W-1:0];
        end
        n_num = num_v;
        n_rem = rem_v;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == fhs_pkg::MOD_CW'(fhs_pkg::MOD_CHUNK - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- hw/rtl/fire_heat_simulation_core.sv -----
// Fire heat simulation core: one heat byte per ring pixel, advanced a frame at a time.
// Depends on fhs_pkg, fhs_ram and fhs_mod_unit.
//
// After reset the core sweeps the heat RAM to zero, one cell a cycle over all RING_MAX
// cells, and takes no item meanwhile; register writes are taken during the sweep.
// Items are handled one at a time. An in-range read passes through ST_RD_PAL, which maps
// the cell to a fire colour, then ST_RESP, which places the result. An advance cools each
// cell, blurs the ring and places each spark, position first. The pace is set by the
// shared remainder unit, which works eight dividend bits a cycle and serves every random
// draw, and by the single read and single write port of the heat RAM. A zero-length
// advance goes straight to ST_RESP.
`timescale 1ns / 1ps

module fire_heat_simulation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_pixel_index,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_index_ok,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = fhs_pkg::HEAT_AW;
    localparam int LW = fhs_pkg::LEN_W;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] a;
        a = x ^ (x << 13);
        a = a ^ (a >> 17);
        a = a ^ (a << 5);
        return a;
    endfunction

    // Registers
    logic [7:0]        r_cooling;
    logic [7:0]        r_spark_rate;
    logic [LW-1:0]     r_ring_length;
    logic [31:0]       r_seed;

    fhs_pkg::t_state   r_state, n_state;
    logic [AW-1:0]     r_idx, n_idx;
    logic [7:0]        r_left, n_left;
    logic [7:0]        r_cur, n_cur;
    logic [7:0]        r_next, n_next;
    logic [7:0]        r_new0, n_new0;
    logic [19:0]       r_prod, n_prod;
    logic [AW-1:0]     r_pos, n_pos;
    logic [1:0]        r_spk_cnt, n_spk_cnt;
    logic [31:0]       r_prng, n_prng;
    logic [7:0]        r_res_red, n_res_red;
    logic [7:0]        r_res_green, n_res_green;
    logic [7:0]        r_res_blue, n_res_blue;
    logic              r_res_ok, n_res_ok;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_red, n_out_red;
    logic [7:0]        r_out_green, n_out_green;
    logic [7:0]        r_out_blue, n_out_blue;
    logic              r_out_ok, n_out_ok;

    // Heat RAM and remainder unit hookup
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [7:0]        mem_rdata;
    fhs_pkg::t_mod_req mod_req;
    fhs_pkg::t_mod_rsp mod_rsp;

    // Derived values
    logic              cfg_wr;
    logic [LW-1:0]     act_len;
    logic [LW-1:0]     len_m1;
    logic [31:0]       prng_step;
    logic [13:0]       cool_prod;
    logic [14:0]       cool_q;
    logic [5:0]        cool;
    logic [LW-1:0]     cool_div;
    logic              in_accept;
    logic              out_free;

    fhs_ram #(
        .WIDTH (8),
        .DEPTH (fhs_pkg::RING_MAX)
    ) u_heat_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    fhs_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    // Register port
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cooling     <= fhs_pkg::COOL_RESET;
            r_spark_rate  <= fhs_pkg::SPARK_RESET;
            r_ring_length <= fhs_pkg::LEN_RESET;
            r_seed        <= fhs_pkg::SEED_RESET;
        end else if (cfg_wr) begin
            unique case (fhs_pkg::t_cfg_reg'(paddr[3:2]))
                fhs_pkg::CFG_COOLING: r_cooling     <= pwdata[7:0];
                fhs_pkg::CFG_SPARK:   r_spark_rate  <= pwdata[7:0];
                fhs_pkg::CFG_LENGTH:  r_ring_length <= pwdata[LW-1:0];
                fhs_pkg::CFG_SEED:    r_seed        <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (fhs_pkg::t_cfg_reg'(paddr[3:2]))
            fhs_pkg::CFG_COOLING: prdata = {24'd0, r_cooling};
            fhs_pkg::CFG_SPARK:   prdata = {24'd0, r_spark_rate};
            fhs_pkg::CFG_LENGTH:  prdata = {{(32 - LW){1'b0}}, r_ring_length};
            fhs_pkg::CFG_SEED:    prdata = r_seed;
        endcase
    end

    // Active length, cooling divisor (cool = 55 - x/255 with x = intensity*40)
    assign act_len   = (r_ring_length > LW'(fhs_pkg::RING_MAX)) ?
                       LW'(fhs_pkg::RING_MAX) : r_ring_length;
    assign len_m1    = act_len - 1'b1;
    assign prng_step = xorshift32(r_prng);
    assign cool_prod = 14'(r_cooling) * fhs_pkg::COOL_SCALE;
    assign cool_q    = 15'(cool_prod) + 15'd1 + 15'(cool_prod >> 8);
    assign cool      = fhs_pkg::COOL_BASE - cool_q[13:8];
    assign cool_div  = LW'(cool) + 1'b1;

    // Handshakes
    assign o_in_stall = (r_state != fhs_pkg::ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Sequencer: next state, RAM and remainder unit control
    always_comb begin
        logic [8:0] spark_v;
        logic [9:0] blur_sum;
        logic [7:0] right_v;
        logic [7:0] blur_new;

        n_state     = r_state;
        n_idx       = r_idx;
        n_left      = r_left;
        n_cur       = r_cur;
        n_next      = r_next;
        n_new0      = r_new0;
        n_prod      = r_prod;
        n_pos       = r_pos;
        n_spk_cnt   = r_spk_cnt;
        n_prng      = r_prng;
        n_res_red   = r_res_red;
        n_res_green = r_res_green;
        n_res_blue  = r_res_blue;
        n_res_ok    = r_res_ok;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_red   = r_out_red;
        n_out_green = r_out_green;
        n_out_blue  = r_out_blue;
        n_out_ok    = r_out_ok;

        mem_we   = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_idx;
        mod_req.start    = 1'b0;
        mod_req.dividend = prng_step;
        mod_req.divisor  = cool_div;

        spark_v  = 9'({1'b0, mem_rdata} + fhs_pkg::SPARK_BASE + mod_rsp.rem);
        right_v  = mem_rdata;
        blur_sum = '0;
        blur_new = r_prod[fhs_pkg::BLUR_SHIFT +: 8];

        unique case (r_state)
            // zero the heat cells after reset
            fhs_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                n_idx     = r_idx + 1'b1;
                if (r_idx == AW'(fhs_pkg::RING_MAX - 1)) begin
                    n_state = fhs_pkg::ST_IDLE;
                end
            end

            fhs_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_res_red   = '0;
                    n_res_green = '0;
                    n_res_blue  = '0;
                    n_res_ok    = 1'b0;
                    n_idx       = '0;
                    if (i_action == fhs_pkg::ACT_READ) begin
                        if (LW'(i_pixel_index) < act_len) begin
                            mem_re    = 1'b1;
                            mem_raddr = AW'(i_pixel_index);
                            n_state   = fhs_pkg::ST_RD_PAL;
                        end else begin
                            n_state = fhs_pkg::ST_RESP;
                        end
                    end else if (act_len == '0) begin
                        n_state = fhs_pkg::ST_RESP;
                    end else begin
                        n_state = fhs_pkg::ST_CL_DRAW;
                    end
                end
            end

            // fire palette of the cell just read
            fhs_pkg::ST_RD_PAL: begin
                n_res_ok = 1'b1;
                if (mem_rdata < fhs_pkg::PAL_LOW) begin
                    n_res_red = 8'(mem_rdata * 8'd3);
                end else if (mem_rdata < fhs_pkg::PAL_HIGH) begin
                    n_res_red   = fhs_pkg::HEAT_FULL;
                    n_res_green = 8'((mem_rdata - fhs_pkg::PAL_LOW) * 8'd3);
                end else begin
                    n_res_red   = fhs_pkg::HEAT_FULL;
                    n_res_green = fhs_pkg::HEAT_FULL;
                    n_res_blue  = 8'((mem_rdata - fhs_pkg::PAL_HIGH) * 8'd3);
                end
                n_state = fhs_pkg::ST_RESP;
            end

            // cooling: draw, reduce mod (cool+1), subtract with floor at zero
            fhs_pkg::ST_CL_DRAW: begin
                n_prng           = prng_step;
                mod_req.start    = 1'b1;
                mod_req.dividend = prng_step;
                mod_req.divisor  = cool_div;
                mem_re           = 1'b1;
                mem_raddr        = r_idx;
                n_state          = fhs_pkg::ST_CL_DIV;
            end

            fhs_pkg::ST_CL_DIV: begin
                if (mod_rsp.done) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = ({1'b0, mem_rdata} > mod_rsp.rem) ?
                                (mem_rdata - mod_rsp.rem[7:0]) : 8'd0;
                    if (LW'(r_idx) == len_m1) begin
                        n_state = fhs_pkg::ST_BL_INIT0;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = fhs_pkg::ST_CL_DRAW;
                    end
                end
            end

            // blur: prime the window with the last cell and cell zero
            fhs_pkg::ST_BL_INIT0: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(len_m1);
                n_state   = fhs_pkg::ST_BL_INIT1;
            end

            fhs_pkg::ST_BL_INIT1: begin
                n_left    = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = '0;
                n_state   = fhs_pkg::ST_BL_INIT2;
            end

            fhs_pkg::ST_BL_INIT2: begin
                n_cur   = mem_rdata;
                n_idx   = '0;
                n_state = fhs_pkg::ST_BL_RD;
            end

            fhs_pkg::ST_BL_RD: begin
                if (LW'(r_idx) != len_m1) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx + 1'b1;
                end
                n_state = fhs_pkg::ST_BL_SUM;
            end

            // last cell wraps to the already blurred cell zero (or itself when L is 1)
            fhs_pkg::ST_BL_SUM: begin
                if (LW'(r_idx) == len_m1) begin
                    right_v = (r_idx == '0) ? r_cur : r_new0;
                end
                n_next   = right_v;
                blur_sum = 10'(r_left) + 10'(r_cur) + 10'(right_v);
                n_prod   = 20'(blur_sum) * fhs_pkg::BLUR_RECIP;
                n_state  = fhs_pkg::ST_BL_WR;
            end

            fhs_pkg::ST_BL_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = blur_new;
                n_left    = blur_new;
                n_cur     = r_next;
                if (r_idx == '0) begin
                    n_new0 = blur_new;
                end
                if (LW'(r_idx) == len_m1) begin
                    n_spk_cnt = r_spark_rate[7:6];
                    n_state   = fhs_pkg::ST_SP_DRAWP;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = fhs_pkg::ST_BL_RD;
                end
            end

            // sparks: position first, then amount
            fhs_pkg::ST_SP_DRAWP: begin
                n_prng           = prng_step;
                mod_req.start    = 1'b1;
                mod_req.dividend = prng_step;
                mod_req.divisor  = act_len;
                n_state          = fhs_pkg::ST_SP_DIVP;
            end

            fhs_pkg::ST_SP_DIVP: begin
                if (mod_rsp.done) begin
                    n_pos   = mod_rsp.rem[AW-1:0];
                    n_state = fhs_pkg::ST_SP_DRAWA;
                end
            end

            fhs_pkg::ST_SP_DRAWA: begin
                n_prng           = prng_step;
                mod_req.start    = 1'b1;
                mod_req.dividend = prng_step;
                mod_req.divisor  = fhs_pkg::SPARK_SPAN;
                mem_re           = 1'b1;
                mem_raddr        = r_pos;
                n_state          = fhs_pkg::ST_SP_DIVA;
            end

            fhs_pkg::ST_SP_DIVA: begin
                if (mod_rsp.done) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = spark_v[8] ? fhs_pkg::HEAT_FULL : spark_v[7:0];
                    if (r_spk_cnt == '0) begin
                        n_res_ok = 1'b1;
                        n_state  = fhs_pkg::ST_RESP;
                    end else begin
                        n_spk_cnt = r_spk_cnt - 1'b1;
                        n_state   = fhs_pkg::ST_SP_DRAWP;
                    end
                end
            end

            // hand the result to the output register once it is free
            fhs_pkg::ST_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_red   = r_res_red;
                    n_out_green = r_res_green;
                    n_out_blue  = r_res_blue;
                    n_out_ok    = r_res_ok;
                    n_state     = fhs_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = fhs_pkg::ST_IDLE;
            end
        endcase

        // a seed write reloads the generator
        if (cfg_wr && (fhs_pkg::t_cfg_reg'(paddr[3:2]) == fhs_pkg::CFG_SEED)) begin
            n_prng = pwdata;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fhs_pkg::ST_CLEAR;
            r_idx       <= '0;
            r_spk_cnt   <= '0;
            r_prng      <= fhs_pkg::SEED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_spk_cnt   <= n_spk_cnt;
            r_prng      <= n_prng;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_left      <= n_left;
        r_cur       <= n_cur;
        r_next      <= n_next;
        r_new0      <= n_new0;
        r_prod      <= n_prod;
        r_pos       <= n_pos;
        r_res_red   <= n_res_red;
        r_res_green <= n_res_green;
        r_res_blue  <= n_res_blue;
        r_res_ok    <= n_res_ok;
        r_out_red   <= n_out_red;
        r_out_green <= n_out_green;
        r_out_blue  <= n_out_blue;
        r_out_ok    <= n_out_ok;
    end

    assign o_out_valid = r_out_valid;
    assign o_red       = r_out_red;
    assign o_green     = r_out_green;
    assign o_blue      = r_out_blue;
    assign o_index_ok  = r_out_ok;

endmodule

// ----- hw/rtl/fhs_checker.sv -----
// Port-level checks for the fire heat simulation core, bound to the top level.
// Depends on fire_heat_simulation_core_assert.svh and fire_heat_simulation_core.
`timescale 1ns / 1ps
`include "fire_heat_simulation_core_assert.svh"

module fhs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic       o_index_ok
);

    // one item at a time: an accepted item closes the input side
    `FHS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a stalled result holds
    `FHS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue) && $stable(o_index_ok))

    // failed reads and empty advances are dark
    `FHS_ASSERT_IMP(a_not_ok_dark, i_clk, i_rst_n, o_out_valid && !o_index_ok, o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0)

    // palette fills red before green or blue
    `FHS_ASSERT_IMP(a_palette_order, i_clk, i_rst_n, o_out_valid && (o_green != 8'd0 || o_blue != 8'd0), o_red == 8'hFF)

endmodule

bind fire_heat_simulation_core fhs_checker u_fhs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_red       (o_red),
    .o_green     (o_green),
    .o_blue      (o_blue),
    .o_index_ok  (o_index_ok)
);

// ----- verif/tb.sv -----
// Self-checking testbench for fire_heat_simulation_core: directed table, then random frames.
// Depends on fhs_pkg and the core RTL; carries its own mirror of the heat ring and generator.
// Items flow with random bursts and gaps; results are checked in order against the mirror or the table.
`timescale 1ns / 1ps

module tb;
    import fhs_pkg::*;

    localparam int IDLE_LIMIT   = 30000;  // several slowest advances plus the long hold
    localparam int HOLD_CYCLES  = 1200;
    localparam int DRAIN_CYCLES = 2500;   // about one full-ring advance
    localparam int RAND_PHASES  = 24;
    localparam int PHASE_ITEMS  = 40;
    localparam int SPARK_STEP   = 64;
    localparam int PLAN_ROWS    = 35;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       ok;
    } t_pixel_rsp;

    typedef struct packed {
        logic       action;
        logic [7:0] pix;
        logic       typed;
        t_pixel_rsp want;
    } t_item;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_cfg_reg    cfg_sel;
        logic [31:0] cfg_val;
        logic        action;
        logic [7:0]  pix;
        logic        typed;
        t_pixel_rsp  want;
    } t_plan_row;

    localparam t_pixel_rsp BLACK_OK  = '{8'd0, 8'd0, 8'd0, 1'b1};
    localparam t_pixel_rsp BLACK_BAD = '{8'd0, 8'd0, 8'd0, 1'b0};

    // DUT signals
    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_action;
    logic [7:0]  i_pixel_index;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        o_index_ok;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Mirror of the block state and registers
    logic [7:0]  heat_mirror [RING_MAX];
    logic [31:0] rng_mirror;
    logic [7:0]  cool_reg;
    logic [7:0]  spark_reg;
    logic [8:0]  len_reg;

    t_item       send_q [$];
    t_pixel_rsp  color_due_q [$];
    t_item       cur_item;
    t_plan_row   plan [PLAN_ROWS];

    bit          offering;
    bit          in_took;
    int          burst_left;
    int          gap_left;
    int          hold_reqs;
    int          hold_done;
    int          hold_left;
    int          rx_mode;
    int          mode_left;
    int          quiet_cycles;
    int          fail_count;

    fire_heat_simulation_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_pixel_index (i_pixel_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_index_ok    (o_index_ok),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // xorshift32 step on the mirrored generator
    function automatic logic [31:0] rng_step();
        logic [31:0] x;
        x = rng_mirror;
        x ^= x << 13;
        x ^= x >> 17;
        x ^= x << 5;
        rng_mirror = x;
        return x;
    endfunction

    // One frame: cool, blur in place, then sparks
    function automatic void advance_frame(int unsigned len);
        int unsigned cool, dec, left, right, sum, nspark, pos, add, v;
        cool = COOL_BASE - (int'(cool_reg) * COOL_SCALE) / HEAT_FULL;
        for (int unsigned i = 0; i < len; i++) begin
            dec = rng_step() % (cool + 1);
            heat_mirror[i] = (heat_mirror[i] > dec) ? heat_mirror[i] - dec : 8'd0;
        end
        for (int unsigned i = 0; i < len; i++) begin
            left  = (i + len - 1) % len;
            right = (i + 1) % len;
            sum   = heat_mirror[i] + heat_mirror[left] + heat_mirror[right];
            heat_mirror[i] = sum / 3;
        end
        nspark = 1 + spark_reg / SPARK_STEP;
        for (int unsigned s = 0; s < nspark; s++) begin
            pos = rng_step() % len;
            add = SPARK_BASE + rng_step() % SPARK_SPAN;
            v   = heat_mirror[pos] + add;
            heat_mirror[pos] = (v > HEAT_FULL) ? HEAT_FULL : v;
        end
    endfunction

    // Fire palette: black to red, red to yellow, yellow to white
    function automatic t_pixel_rsp heat_color(logic [7:0] t);
        t_pixel_rsp c;
        c    = '0;
        c.ok = 1'b1;
        if (t < PAL_LOW) begin
            c.red = t * 3;
        end else if (t < PAL_HIGH) begin
            c.red   = HEAT_FULL;
            c.green = (t - PAL_LOW) * 3;
        end else begin
            c.red   = HEAT_FULL;
            c.green = HEAT_FULL;
            c.blue  = (t - PAL_HIGH) * 3;
        end
        return c;
    endfunction

    function automatic t_pixel_rsp predict_item(logic action, logic [7:0] pix);
        int unsigned len;
        t_pixel_rsp  rsp;
        len = (len_reg > RING_MAX) ? RING_MAX : len_reg;
        rsp = '0;
        if (action == ACT_ADVANCE) begin
            if (len != 0) begin
                advance_frame(len);
                rsp.ok = 1'b1;
            end
        end else if (pix < len) begin
            rsp = heat_color(heat_mirror[pix]);
        end
        return rsp;
    endfunction

    function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endfunction

    // Register write: setup cycle, then access cycle; mirror follows at the write edge
    task automatic reg_write(t_cfg_reg sel, logic [31:0] v);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 2'b00};
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (sel)
            CFG_COOLING: cool_reg = v[7:0];
            CFG_SPARK:   spark_reg = v[7:0];
            CFG_LENGTH:  len_reg = v[8:0];
            CFG_SEED:    rng_mirror = v;
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Block is idle once every queued item went in and its result came out
    task automatic wait_quiet();
        while (send_q.size() != 0 || offering || color_due_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Item sender: bursts of random length with random gaps
    always @(negedge i_clk) begin
        if (offering && in_took) begin
            offering = 1'b0;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                burst_left = $urandom_range(1, 20);
            end
        end
        if (!offering) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (send_q.size() > 0) begin
                cur_item = send_q.pop_front();
                offering = 1'b1;
            end
        end
        i_in_valid <= offering;
        if (offering) begin
            i_action      <= cur_item.action;
            i_pixel_index <= cur_item.pix;
        end
    end

    // Result receiver: stall pattern by mode, plus requested long holds
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_done != hold_reqs) begin
            hold_done++;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 150);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= $urandom_range(0, 1);
            endcase
        end
    end

    // Result check first (oldest expectation), then prediction for an accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (color_due_q.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, got %0d/%0d/%0d/%0d",
                         $time, o_red, o_green, o_blue, o_index_ok);
                fail_count++;
            end else begin
                t_pixel_rsp w;
                w = color_due_q.pop_front();
                check_field("red", w.red, o_red);
                check_field("green", w.green, o_green);
                check_field("blue", w.blue, o_blue);
                check_field("index_ok", {7'd0, w.ok}, {7'd0, o_index_ok});
            end
        end
        in_took = i_rst_n && i_in_valid && !o_in_stall;
        if (in_took) begin
            t_pixel_rsp p;
            p = predict_item(i_action, i_pixel_index);
            color_due_q.push_back(cur_item.typed ? cur_item.want : p);
        end
    end

    // Watchdog on cycles without any accepted item, taken result or register access
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int    ph, n, pick, span, lim;
        t_item it;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = ACT_ADVANCE;
        i_pixel_index = 8'd0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        offering = 1'b0;
        in_took = 1'b0;
        burst_left = 1;
        gap_left = 0;
        hold_reqs = 0;
        hold_done = 0;
        hold_left = 0;
        rx_mode = 0;
        mode_left = 0;
        quiet_cycles = 0;
        fail_count = 0;
        cur_item = '0;

        // Mirror after reset
        foreach (heat_mirror[k]) heat_mirror[k] = 8'd0;
        cool_reg   = COOL_RESET;
        spark_reg  = SPARK_RESET;
        len_reg    = LEN_RESET;
        rng_mirror = SEED_RESET;

        // Directed table: kind, register, value, action, index, typed, expected
        plan = '{
            // cleared ring, read edges around the reset length
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd0,   1'b1, BLACK_OK},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd199, 1'b1, BLACK_OK},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd200, 1'b1, BLACK_BAD},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd255, 1'b1, BLACK_BAD},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_ADVANCE, 8'd0,   1'b1, BLACK_OK},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd0,   1'b0, BLACK_OK},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd100, 1'b0, BLACK_OK},
            // empty ring: advance does nothing, every read is out of range
            '{ROW_CFG,  CFG_LENGTH,  32'd0, ACT_READ,    8'd0,   1'b0, BLACK_BAD},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_ADVANCE, 8'd255, 1'b1, BLACK_BAD},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd0,   1'b1, BLACK_BAD},
            // oversize length clamps to the full ring
            '{ROW_CFG,  CFG_LENGTH,  32'd511, ACT_READ,  8'd0,   1'b0, BLACK_BAD},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd255, 1'b1, BLACK_OK},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_ADVANCE, 8'd0,   1'b1, BLACK_OK},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd255, 1'b0, BLACK_OK},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd0,   1'b0, BLACK_OK},
            // least cooling, most sparks, stuck generator, one-cell ring
            '{ROW_CFG,  CFG_COOLING, 32'd255, ACT_READ,  8'd0,   1'b0, BLACK_BAD},
            '{ROW_CFG,  CFG_SPARK,   32'd255, ACT_READ,  8'd0,   1'b0, BLACK_BAD},
            '{ROW_CFG,  CFG_SEED,    32'd0,   ACT_READ,  8'd0,   1'b0, BLACK_BAD},
            '{ROW_CFG,  CFG_LENGTH,  32'd1,   ACT_READ,  8'd0,   1'b0, BLACK_BAD},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_ADVANCE, 8'd0,   1'b1, BLACK_OK},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd0,   1'b0, BLACK_OK},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd1,   1'b1, BLACK_BAD},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_ADVANCE, 8'd0,   1'b1, BLACK_OK},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd0,   1'b0, BLACK_OK},
            // most cooling, fewest sparks, all-ones seed, two-cell ring
            '{ROW_CFG,  CFG_COOLING, 32'd0,   ACT_READ,  8'd0,   1'b0, BLACK_BAD},
            '{ROW_CFG,  CFG_SPARK,   32'd0,   ACT_READ,  8'd0,   1'b0, BLACK_BAD},
            '{ROW_CFG,  CFG_SEED,    32'hFFFF_FFFF, ACT_READ, 8'd0, 1'b0, BLACK_BAD},
            '{ROW_CFG,  CFG_LENGTH,  32'd2,   ACT_READ,  8'd0,   1'b0, BLACK_BAD},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_ADVANCE, 8'd0,   1'b1, BLACK_OK},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd0,   1'b0, BLACK_OK},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd1,   1'b0, BLACK_OK},
            // grow back: cells past the short ring kept their heat
            '{ROW_CFG,  CFG_LENGTH,  32'd256, ACT_READ,  8'd0,   1'b0, BLACK_BAD},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd128, 1'b0, BLACK_OK},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_ADVANCE, 8'd0,   1'b1, BLACK_OK},
            '{ROW_ITEM, CFG_COOLING, 32'd0, ACT_READ,    8'd254, 1'b0, BLACK_OK}
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part
        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (plan[r].kind == ROW_CFG) begin
                wait_quiet();
                reg_write(plan[r].cfg_sel, plan[r].cfg_val);
            end else begin
                it.action = plan[r].action;
                it.pix    = plan[r].pix;
                it.typed  = plan[r].typed;
                it.want   = plan[r].want;
                send_q.push_back(it);
            end
        end

        // Random phases: fresh settings, then a mix of frames and reads
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            wait_quiet();
            pick = $urandom_range(0, 3);
            reg_write(CFG_COOLING, (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 255));
            pick = $urandom_range(0, 3);
            reg_write(CFG_SPARK, (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 255));
            // mostly short rings; a few empty, long (200 to 255) or full-size and oversize ones
            pick = $urandom_range(0, 19);
            if (pick == 0)      span = 0;
            else if (pick == 1) span = $urandom_range(256, 511);
            else if (pick == 2) span = $urandom_range(200, 255);
            else                span = $urandom_range(1, 24);
            reg_write(CFG_LENGTH, span);
            pick = $urandom_range(0, 11);
            if (pick == 0)     reg_write(CFG_SEED, 32'd0);
            else if (pick < 5) reg_write(CFG_SEED, $urandom);
            // one phase runs against a long receiver hold so the input backs up
            if (ph == 1) hold_reqs++;
            lim = (span > RING_MAX) ? RING_MAX : span;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                it.typed = 1'b0;
                it.want  = '0;
                if ($urandom_range(0, 9) < 3) begin
                    it.action = ACT_ADVANCE;
                    it.pix    = $urandom_range(0, 255);
                end else begin
                    it.action = ACT_READ;
                    if (lim != 0 && $urandom_range(0, 4) != 0)
                        it.pix = $urandom_range(0, lim - 1);
                    else
                        it.pix = $urandom_range(0, 255);
                end
                send_q.push_back(it);
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (color_due_q.size() != 0) begin
            $display("%0t: results still due, expected 0, got %0d", $time, color_due_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/fhs_pkg.sv
hw/rtl/fhs_ram.sv
hw/rtl/fhs_mod_unit.sv
hw/rtl/fire_heat_simulation_core.sv
hw/rtl/fhs_checker.sv
verif/tb.sv
